### design/psc_pkg.sv
// Shared types, register indexes and saturation helper for the particle step block.
package psc_pkg;

  typedef enum logic [2:0] {
    CFG_ACCEL_X = 3'd0,
    CFG_ACCEL_Y = 3'd1,
    CFG_TIME_STEP = 3'd2,
    CFG_X_BOUND = 3'd3,
    CFG_Y_BOUND = 3'd4
  } cfg_idx_e;

  // One point after the motion update, handed to the colour pipeline.
  typedef struct packed {
    logic               valid;
    logic               want;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } kin_t;

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > S32Max) begin
      return 32'sh7fffffff;
    end else if (x < S32Min) begin
      return 32'sh80000000;
    end else begin
      return $signed(x[31:0]);
    end
  endfunction

endpackage

### design/particle_step_with_colour.sv
// Top level: configuration registers, motion pipeline and colour pipeline.
// Fully pipelined: one point may be started every cycle (busy_o stays low) and
// its result appears on the output ports, marked by a one-cycle done_o, after
// the four motion stages, colour stages A and B, the eight two-bit stages of
// the position divider and speed square root, and the output register. Results
// cannot be held off, so the receiver must take each done_o transaction.
// Configuration writes are always ready; change registers only while idle.
module particle_step_with_colour (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic               want_colour_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] next_pos_x_o,
  output logic signed [31:0] next_pos_y_o,
  output logic signed [31:0] next_vel_x_o,
  output logic signed [31:0] next_vel_y_o,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  output logic               colour_valid_o
);

  logic signed [31:0] accel_x_q, accel_y_q;
  logic [30:0]        time_step_q, x_bound_q, y_bound_q;
  psc_pkg::kin_t      kin;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_x_q   <= '0;
      accel_y_q   <= '0;
      time_step_q <= 31'd1677;
      x_bound_q   <= 31'd16777216;
      y_bound_q   <= 31'd8388608;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (psc_pkg::cfg_idx_e'(cfg_index_i))
        psc_pkg::CFG_ACCEL_X:   accel_x_q   <= cfg_data_i;
        psc_pkg::CFG_ACCEL_Y:   accel_y_q   <= cfg_data_i;
        psc_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i[30:0];
        psc_pkg::CFG_X_BOUND:   x_bound_q   <= cfg_data_i[30:0];
        psc_pkg::CFG_Y_BOUND:   y_bound_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  psc_motion u_motion (
    .clk_i,
    .rst_ni,
    .in_valid_i   (start_i && !busy_o),
    .pos_x_i,
    .pos_y_i,
    .vel_x_i,
    .vel_y_i,
    .want_colour_i,
    .accel_x_i    (accel_x_q),
    .accel_y_i    (accel_y_q),
    .time_step_i  (time_step_q),
    .x_bound_i    (x_bound_q),
    .y_bound_i    (y_bound_q),
    .kin_o        (kin)
  );

  psc_colour u_colour (
    .clk_i,
    .rst_ni,
    .kin_i        (kin),
    .x_bound_i    (x_bound_q),
    .y_bound_i    (y_bound_q),
    .done_o,
    .next_pos_x_o,
    .next_pos_y_o,
    .next_vel_x_o,
    .next_vel_y_o,
    .red_o,
    .green_o,
    .blue_o,
    .colour_valid_o
  );

endmodule

### design/psc_motion.sv
// Four-stage kinematic update: accel*dt, half-step velocity, displacement, clamp and reflect.
module psc_motion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic               want_colour_i,
  input  logic signed [31:0] accel_x_i,
  input  logic signed [31:0] accel_y_i,
  input  logic [30:0]        time_step_i,
  input  logic [30:0]        x_bound_i,
  input  logic [30:0]        y_bound_i,
  output psc_pkg::kin_t      kin_o
);

  logic [3:0] vld_q;

  logic signed [31:0] dt_s;
  logic signed [63:0] adtx_d, adty_d;
  assign dt_s = $signed({1'b0, time_step_i});
  assign adtx_d = accel_x_i * dt_s;
  assign adty_d = accel_y_i * dt_s;

  // stage 1
  logic signed [31:0] px1_q, py1_q, vx1_q, vy1_q;
  logic               w1_q;
  logic signed [63:0] adtx1_q, adty1_q;

  // stage 2
  logic signed [31:0] px2_q, py2_q, ux2_q, uy2_q, nvx2_q, nvy2_q;
  logic               w2_q;
  logic signed [31:0] ux_d, uy_d, nvx_d, nvy_d;
  assign ux_d = psc_pkg::sat32(64'(vx1_q) + (adtx1_q >>> 25));
  assign uy_d = psc_pkg::sat32(64'(vy1_q) + (adty1_q >>> 25));
  assign nvx_d = psc_pkg::sat32(64'(vx1_q) + (adtx1_q >>> 24));
  assign nvy_d = psc_pkg::sat32(64'(vy1_q) + (adty1_q >>> 24));

  // stage 3
  logic signed [31:0] px3_q, py3_q, nvx3_q, nvy3_q;
  logic               w3_q;
  logic signed [63:0] udtx3_q, udty3_q, udtx_d, udty_d;
  assign udtx_d = ux2_q * dt_s;
  assign udty_d = uy2_q * dt_s;

  // stage 4: clamp at the walls, reflect an outward velocity
  logic signed [63:0] npx, npy, bx, by;
  logic signed [31:0] px_d, py_d, vx_d, vy_d;
  psc_pkg::kin_t      kin_q;

  assign npx = 64'(px3_q) + (udtx3_q >>> 24);
  assign npy = 64'(py3_q) + (udty3_q >>> 24);
  assign bx = $signed({33'd0, x_bound_i});
  assign by = $signed({33'd0, y_bound_i});

  always_comb begin
    px_d = npx[31:0];
    vx_d = nvx3_q;
    if (npx > bx) begin
      px_d = bx[31:0];
      if (!nvx3_q[31]) vx_d = psc_pkg::sat32(-64'(nvx3_q));
    end else if (npx < -bx) begin
      px_d = 32'(-bx);
      if (nvx3_q[31] || nvx3_q == 32'sd0) vx_d = psc_pkg::sat32(-64'(nvx3_q));
    end
    py_d = npy[31:0];
    vy_d = nvy3_q;
    if (npy > by) begin
      py_d = by[31:0];
      if (!nvy3_q[31]) vy_d = psc_pkg::sat32(-64'(nvy3_q));
    end else if (npy < -by) begin
      py_d = 32'(-by);
      if (nvy3_q[31] || nvy3_q == 32'sd0) vy_d = psc_pkg::sat32(-64'(nvy3_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    px1_q   <= pos_x_i;
    py1_q   <= pos_y_i;
    vx1_q   <= vel_x_i;
    vy1_q   <= vel_y_i;
    w1_q    <= want_colour_i;
    adtx1_q <= adtx_d;
    adty1_q <= adty_d;

    px2_q  <= px1_q;
    py2_q  <= py1_q;
    ux2_q  <= ux_d;
    uy2_q  <= uy_d;
    nvx2_q <= nvx_d;
    nvy2_q <= nvy_d;
    w2_q   <= w1_q;

    px3_q   <= px2_q;
    py3_q   <= py2_q;
    nvx3_q  <= nvx2_q;
    nvy3_q  <= nvy2_q;
    udtx3_q <= udtx_d;
    udty3_q <= udty_d;
    w3_q    <= w2_q;

    kin_q.valid <= vld_q[2];
    kin_q.want  <= w3_q;
    kin_q.px    <= px_d;
    kin_q.py    <= py_d;
    kin_q.vx    <= vx_d;
    kin_q.vy    <= vy_d;
  end

  always_comb begin
    kin_o       = kin_q;
    kin_o.valid = vld_q[3];
  end

endmodule

### design/psc_colour.sv
// Colour pipeline: squares, then pipelined position divide and speed square root.
module psc_colour (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psc_pkg::kin_t      kin_i,
  input  logic [30:0]        x_bound_i,
  input  logic [30:0]        y_bound_i,
  output logic               done_o,
  output logic signed [31:0] next_pos_x_o,
  output logic signed [31:0] next_pos_y_o,
  output logic signed [31:0] next_vel_x_o,
  output logic signed [31:0] next_vel_y_o,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  output logic               colour_valid_o
);

  localparam int Iters = 8;  // two quotient/root bits per stage

  typedef struct packed {
    logic               want;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [32:0]        rx;
    logic [32:0]        ry;
    logic [32:0]        dx;
    logic [32:0]        dy;
    logic [15:0]        qx;
    logic [15:0]        qy;
    logic               sx;
    logic               sy;
    logic               zx;
    logic               zy;
    logic [31:0]        n;
    logic [31:0]        root;
    logic               so;
  } col_t;

  function automatic col_t iter_step(input col_t c, input int idx);
    col_t        r;
    logic [32:0] t;
    logic [31:0] bitv;
    r = c;
    t = {r.rx[31:0], 1'b0};
    if (t >= r.dx) begin
      r.rx = t - r.dx;
      r.qx = {r.qx[14:0], 1'b1};
    end else begin
      r.rx = t;
      r.qx = {r.qx[14:0], 1'b0};
    end
    t = {r.ry[31:0], 1'b0};
    if (t >= r.dy) begin
      r.ry = t - r.dy;
      r.qy = {r.qy[14:0], 1'b1};
    end else begin
      r.ry = t;
      r.qy = {r.qy[14:0], 1'b0};
    end
    bitv = 32'd1 << (30 - 2 * idx);
    if (r.n >= r.root + bitv) begin
      r.n = r.n - (r.root + bitv);
      r.root = (r.root >> 1) + bitv;
    end else begin
      r.root = r.root >> 1;
    end
    return r;
  endfunction

  // stage A: squares of velocity, shifted positions, divisors
  logic [Iters+2:0]   vld_q;
  psc_pkg::kin_t      ka_q;
  logic [63:0]        sqx_q, sqy_q;
  logic [32:0]        sxa_q, sya_q;
  logic [32:0]        dxa_q, dya_q;
  logic signed [33:0] spx, spy;

  assign spx = 34'(kin_i.px) + $signed({3'd0, x_bound_i});
  assign spy = 34'(kin_i.py) + $signed({3'd0, y_bound_i});

  always_ff @(posedge clk_i) begin
    ka_q  <= kin_i;
    sqx_q <= 64'(kin_i.vx * kin_i.vx);
    sqy_q <= 64'(kin_i.vy * kin_i.vy);
    sxa_q <= spx[32:0];
    sya_q <= spy[32:0];
    dxa_q <= {1'b0, x_bound_i, 1'b0};
    dya_q <= {1'b0, y_bound_i, 1'b0};
  end

  // stage B: sum of squares, integer bit of each quotient
  col_t        st_q [Iters+1];
  col_t        init_d;
  logic [63:0] sq;

  assign sq = sqx_q + sqy_q;

  always_comb begin
    init_d.want = ka_q.want;
    init_d.px   = ka_q.px;
    init_d.py   = ka_q.py;
    init_d.vx   = ka_q.vx;
    init_d.vy   = ka_q.vy;
    init_d.dx   = dxa_q;
    init_d.dy   = dya_q;
    init_d.zx   = (dxa_q == 33'd0);
    init_d.zy   = (dya_q == 33'd0);
    init_d.sx   = (sxa_q >= dxa_q);
    init_d.sy   = (sya_q >= dya_q);
    init_d.rx   = init_d.sx ? sxa_q - dxa_q : sxa_q;
    init_d.ry   = init_d.sy ? sya_q - dya_q : sya_q;
    init_d.qx   = '0;
    init_d.qy   = '0;
    init_d.so   = |sq[63:48];
    init_d.n    = sq[47:16];
    init_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= init_d;
  end

  for (genvar k = 0; k < Iters; k++) begin : g_iter
    always_ff @(posedge clk_i) begin
      st_q[k+1] <= iter_step(iter_step(st_q[k], 2 * k), 2 * k + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Iters+1:0], kin_i.valid};
    end
  end

  col_t fin;
  assign fin = st_q[Iters];

  always_ff @(posedge clk_i) begin
    next_pos_x_o <= fin.px;
    next_pos_y_o <= fin.py;
    next_vel_x_o <= fin.vx;
    next_vel_y_o <= fin.vy;
    colour_valid_o <= fin.want;
    if (!fin.want || fin.zx) red_o <= '0;
    else if (fin.sx) red_o <= 16'hffff;
    else red_o <= fin.qx;
    if (!fin.want || fin.zy) green_o <= '0;
    else if (fin.sy) green_o <= 16'hffff;
    else green_o <= fin.qy;
    if (!fin.want) blue_o <= '0;
    else if (fin.so) blue_o <= 16'hffff;
    else blue_o <= fin.root[15:0];
  end

  assign done_o = vld_q[Iters+2];

endmodule
